/* design/potb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_pkg
// shared types and constants for the periodic / one-shot timer bank
// ----------------------------------------------------------------------------
package potb_pkg;

	localparam int TIMER_COUNT = 16;
	localparam int MAX_RESULTS = 16;

	localparam int ID_W     = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
	localparam int OP_W     = 2;
	localparam int TID_W    = 8;
	localparam int PERIOD_W = 16;
	localparam int OUT_ID_W = 6;

	// command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	// result queue, deep enough for one whole tick
	localparam int RES_DEPTH = (MAX_RESULTS > 1) ? MAX_RESULTS : 2;
	localparam int RQ_AW     = $clog2(RES_DEPTH);
	localparam int RQ_CW     = $clog2(RES_DEPTH + 1);
	localparam int NR_W      = $clog2(MAX_RESULTS + 1);

	typedef enum logic [OP_W-1:0] {
		OP_SETUP = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [ID_W-1:0]     id;
		logic [PERIOD_W-1:0] period;
		logic                run_once;
		logic                has_target;
		logic                has_handler;
		logic                clear_count;
	} cmd_t;

	typedef struct packed {
		logic [OUT_ID_W-1:0] id;
		logic                post_event;
		logic                call_handler;
		logic                is_last;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_WALK = 2'd1,
		BK_DONE = 2'd2
	} bk_state_t;

endpackage

/* design/potb_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_ram
// generic single write port / single read port ram with registered read
// ----------------------------------------------------------------------------
module potb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/potb_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_front
// input side: accepts items, drops out-of-range timer numbers, queues commands
// ----------------------------------------------------------------------------
module potb_front
	import potb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [OP_W-1:0]     operation,
	input  logic [TID_W-1:0]    timer_id,
	input  logic [PERIOD_W-1:0] period,
	input  logic                run_once,
	input  logic                has_target,
	input  logic                has_handler,
	input  logic                clear_count,
	output logic                cmd_valid,
	output cmd_t                cmd,
	input  logic                cmd_pop
);

	cmd_t             buf_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CQ_CW-1:0] cnt_q;
	logic             accept, keep;
	op_t              op;
	cmd_t             new_cmd;

	assign op     = op_t'(operation);
	assign full   = (cnt_q == CQ_CW'(CQ_DEPTH));
	assign accept = push && !full;
	// tick ignores the timer number, the others need it in range
	assign keep   = accept && ((op == OP_TICK) || (timer_id < TID_W'(TIMER_COUNT)));

	assign cmd_valid = (cnt_q != '0);
	assign cmd       = buf_q[rd_ptr_q];

	always_comb begin
		new_cmd             = '0;
		new_cmd.op          = op;
		new_cmd.id          = timer_id[ID_W-1:0];
		new_cmd.period      = period;
		new_cmd.run_once    = run_once;
		new_cmd.has_target  = has_target;
		new_cmd.has_handler = has_handler;
		new_cmd.clear_count = clear_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (keep) begin
				wr_ptr_q <= (wr_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + CQ_AW'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + CQ_AW'(1);
			end
			if (keep && !cmd_pop) begin
				cnt_q <= cnt_q + CQ_CW'(1);
			end else if (!keep && cmd_pop) begin
				cnt_q <= cnt_q - CQ_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			buf_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

/* design/potb_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_back
// execution side: timer state, set up / start / stop, and the tick walk
// ----------------------------------------------------------------------------
module potb_back
	import potb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_empty,
	output logic res_push,
	output res_t res_data
);

	localparam logic [ID_W-1:0] LAST_ID = ID_W'(TIMER_COUNT - 1);

	bk_state_t state_q, state_d;

	logic [TIMER_COUNT-1:0] enabled_q, one_shot_q, target_q, handler_q;
	logic [TIMER_COUNT-1:0] pvalid_q, cvalid_q;

	logic [ID_W-1:0] rd_idx_q;
	logic            issue_q;
	logic            v_s1, pv_s1, cv_s1;
	logic [ID_W-1:0] idx_s1;

	res_t            held_q;
	logic            held_v_q;
	logic [NR_W-1:0] n_q;

	logic                p_we, c_we, rd_en;
	logic [ID_W-1:0]     c_waddr;
	logic [PERIOD_W-1:0] c_wdata;
	logic [PERIOD_W-1:0] p_rdata, c_rdata;

	logic                do_setup, do_startstop, start_tick, done_walk;
	logic [PERIOD_W-1:0] cnt_cur, per_cur, cnt_inc;
	logic                expire, room;
	res_t                new_res;

	potb_ram #(.WIDTH(PERIOD_W), .DEPTH(TIMER_COUNT)) u_period_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (cmd.id),
		.wdata (cmd.period),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (p_rdata)
	);

	potb_ram #(.WIDTH(PERIOD_W), .DEPTH(TIMER_COUNT)) u_count_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (rd_en),
		.raddr (rd_idx_q),
		.rdata (c_rdata)
	);

	// never written entries read as zero
	assign cnt_cur = cv_s1 ? c_rdata : '0;
	assign per_cur = pv_s1 ? p_rdata : '0;
	assign cnt_inc = cnt_cur + PERIOD_W'(1);
	assign expire  = v_s1 && enabled_q[idx_s1] && (cnt_inc >= per_cur);
	assign room    = (n_q < NR_W'(MAX_RESULTS));

	always_comb begin
		new_res              = '0;
		new_res.id           = OUT_ID_W'(idx_s1);
		new_res.post_event   = target_q[idx_s1];
		new_res.call_handler = handler_q[idx_s1];
	end

	always_comb begin
		state_d      = state_q;
		cmd_pop      = 1'b0;
		do_setup     = 1'b0;
		do_startstop = 1'b0;
		start_tick   = 1'b0;
		done_walk    = 1'b0;
		rd_en        = 1'b0;
		p_we         = 1'b0;
		c_we         = 1'b0;
		c_waddr      = cmd.id;
		c_wdata      = '0;
		res_push     = 1'b0;
		res_data     = held_q;
		res_data.is_last = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_TICK: begin
							// a whole tick must fit in the result queue
							if (res_empty) begin
								cmd_pop    = 1'b1;
								start_tick = 1'b1;
								state_d    = BK_WALK;
							end
						end
						OP_SETUP: begin
							cmd_pop  = 1'b1;
							do_setup = 1'b1;
							p_we     = 1'b1;
							c_we     = 1'b1;
						end
						OP_START, OP_STOP: begin
							cmd_pop      = 1'b1;
							do_startstop = 1'b1;
							c_we         = cmd.clear_count;
						end
						default: begin
						end
					endcase
				end
			end
			BK_WALK: begin
				rd_en = issue_q;
				if (v_s1 && enabled_q[idx_s1]) begin
					c_we    = 1'b1;
					c_waddr = idx_s1;
					c_wdata = expire ? '0 : cnt_inc;
				end
				// push the held result once a newer one replaces it
				if (expire && room && held_v_q) begin
					res_push = 1'b1;
				end
				if (!issue_q) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				done_walk        = 1'b1;
				res_push         = held_v_q;
				res_data.is_last = 1'b1;
				state_d          = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			enabled_q  <= '0;
			one_shot_q <= '0;
			target_q   <= '0;
			handler_q  <= '0;
			pvalid_q   <= '0;
			cvalid_q   <= '0;
			issue_q    <= 1'b0;
			v_s1       <= 1'b0;
			held_v_q   <= 1'b0;
			n_q        <= '0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == BK_WALK) && issue_q;
			if (c_we) begin
				cvalid_q[c_waddr] <= 1'b1;
			end
			if (do_setup) begin
				pvalid_q[cmd.id]   <= 1'b1;
				enabled_q[cmd.id]  <= 1'b0;
				one_shot_q[cmd.id] <= cmd.run_once;
				target_q[cmd.id]   <= cmd.has_target;
				handler_q[cmd.id]  <= cmd.has_handler;
			end
			if (do_startstop) begin
				enabled_q[cmd.id] <= (cmd.op == OP_START);
			end
			if (start_tick) begin
				issue_q <= 1'b1;
				n_q     <= '0;
			end else if ((state_q == BK_WALK) && issue_q && (rd_idx_q == LAST_ID)) begin
				issue_q <= 1'b0;
			end
			if (expire && one_shot_q[idx_s1]) begin
				enabled_q[idx_s1] <= 1'b0;
			end
			if (expire && room) begin
				held_v_q <= 1'b1;
				n_q      <= n_q + NR_W'(1);
			end
			if (done_walk) begin
				held_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_tick) begin
			rd_idx_q <= '0;
		end else if ((state_q == BK_WALK) && issue_q) begin
			rd_idx_q <= rd_idx_q + ID_W'(1);
		end
		idx_s1 <= rd_idx_q;
		pv_s1  <= pvalid_q[rd_idx_q];
		cv_s1  <= cvalid_q[rd_idx_q];
		if (expire && room) begin
			held_q <= new_res;
		end
	end

endmodule

/* design/potb_result_q.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// potb_result_q
// result queue, holds the results of one tick until they are popped
// ----------------------------------------------------------------------------
module potb_result_q
	import potb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  res_t wr_data,
	input  logic pop,
	output logic empty,
	output res_t head
);

	res_t             buf_q [RES_DEPTH];
	logic [RQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [RQ_CW-1:0] cnt_q;
	logic             rd_en;

	assign empty = (cnt_q == '0);
	assign rd_en = pop && !empty;
	assign head  = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == RQ_AW'(RES_DEPTH - 1)) ? '0 : wr_ptr_q + RQ_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == RQ_AW'(RES_DEPTH - 1)) ? '0 : rd_ptr_q + RQ_AW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + RQ_CW'(1);
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - RQ_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* design/periodic_oneshot_timer_bank_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank_unit
// bank of TIMER_COUNT periodic / one-shot timers driven by an operation stream
// ----------------------------------------------------------------------------
// Both sides look like a queue: push an operation while full is low, pop
// expiry results while empty is low. Set up, start and stop are each done
// in the execution stage; a tick walks the timers one per cycle through
// the period and count rams and holds the execution stage while it takes
// the tick, reads each timer, finishes the last timer and posts the last
// result, and it starts only once the result queue has been drained, since
// one tick may produce up to MAX_RESULTS results. A two-entry command
// queue keeps taking operations while a tick runs or results wait. Set up,
// start and stop operations naming a timer number at or above TIMER_COUNT
// are taken and dropped. Each tick gives one result per expiring timer in
// index order, the last one marked by is_last; a tick with no expiry gives
// no result.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank_unit
	import potb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// operation side
	input  logic                push,
	output logic                full,
	input  logic [OP_W-1:0]     operation,
	input  logic [TID_W-1:0]    timer_id,
	input  logic [PERIOD_W-1:0] period,
	input  logic                run_once,
	input  logic                has_target,
	input  logic                has_handler,
	input  logic                clear_count,
	// result side
	output logic                empty,
	input  logic                pop,
	output logic [OUT_ID_W-1:0] expired_id,
	output logic                post_event,
	output logic                call_handler,
	output logic                is_last
);

	// command transfer between front and back
	logic cmd_valid, cmd_pop;
	cmd_t cmd;

	// result transfer into the result queue
	logic res_push, res_empty;
	res_t res_data, res_head;

	potb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.timer_id    (timer_id),
		.period      (period),
		.run_once    (run_once),
		.has_target  (has_target),
		.has_handler (has_handler),
		.clear_count (clear_count),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	potb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_empty (res_empty),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	potb_result_q u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.pop     (pop),
		.empty   (res_empty),
		.head    (res_head)
	);

	// the oldest waiting result sits on the result ports
	assign empty        = res_empty;
	assign expired_id   = res_head.id;
	assign post_event   = res_head.post_event;
	assign call_handler = res_head.call_handler;
	assign is_last      = res_head.is_last;

endmodule
